// ===== hdl/qstg_pkg.sv =====
// Shared types, constants and the sine magnitude function for the queued tone generator.
// Used by every module under hdl/; depends on nothing else.
package qstg_pkg;

  // word field widths
  localparam int FREQ_W   = 19;
  localparam int DUR_W    = 16;
  localparam int AMP_W    = 15;
  localparam int SAMPLE_W = 16;
  localparam int FILL_W   = 5;
  localparam int MAG_W    = 15;
  localparam int PHASE_W  = 32;

  localparam logic [AMP_W-1:0] AMP_RESET = 15'd28000;

  // tone queue
  localparam int QUEUE_DEPTH = 16;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  // result buffer
  localparam int RES_DEPTH = 16;
  localparam int RES_PTR_W = $clog2(RES_DEPTH);
  localparam int RES_CNT_W = $clog2(RES_DEPTH + 1);

  // step = round(freq * 2^28 / SAMPLE_RATE), split as freq*Q0 + (freq*R0 + half)/SAMPLE_RATE
  localparam longint unsigned SAMPLE_RATE = 64'd44100;
  localparam longint unsigned MS_PER_SEC  = 64'd1000;
  localparam longint unsigned STEP_ONE    = 64'd1 << 28;
  localparam longint unsigned STEP_Q0     = STEP_ONE / SAMPLE_RATE;
  localparam longint unsigned STEP_R0     = STEP_ONE % SAMPLE_RATE;
  localparam longint unsigned STEP_HALF   = SAMPLE_RATE / 2;

  localparam longint unsigned X_MAX = ((64'd1 << FREQ_W) - 1) * STEP_R0 + STEP_HALF;
  localparam int              X_W   = $clog2(X_MAX + 1);
  localparam longint unsigned STEP_MX = (64'd1 << X_W) / SAMPLE_RATE;
  localparam int              MX_W  = $clog2(STEP_MX + 1);
  localparam int              Q_W   = $clog2(X_MAX / SAMPLE_RATE + 1);
  localparam int              RX_W  = $clog2(2 * SAMPLE_RATE);

  // count = duration_ms * SAMPLE_RATE / 1000
  localparam longint unsigned Y_MAX  = ((64'd1 << DUR_W) - 1) * SAMPLE_RATE;
  localparam int              Y_W    = $clog2(Y_MAX + 1);
  localparam longint unsigned CNT_MY = (64'd1 << Y_W) / MS_PER_SEC;
  localparam int              MY_W   = $clog2(CNT_MY + 1);
  localparam int              CNT_W  = $clog2(Y_MAX / MS_PER_SEC + 1);
  localparam int              RY_W   = $clog2(2 * MS_PER_SEC);

  localparam longint unsigned PI_Q30 = 64'd3373259426;

  typedef struct packed {
    logic               valid;
    logic               enq;
    logic [PHASE_W-1:0] step;
    logic [CNT_W-1:0]   count;
  } note_t;

  typedef struct packed {
    logic              valid;
    logic              playing;
    logic              rejected;
    logic [FILL_W-1:0] fill;
  } status_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic [FILL_W-1:0]          fill;
    logic                       rejected;
    logic                       playing;
  } res_t;

  // Quarter-wave entry idx of a table with 2^bits steps: Q30 Taylor series, rounded to Q15.
  function automatic logic [MAG_W-1:0] sine_mag(input int idx, input int bits);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] sum;
    logic [63:0] prod;
    logic [63:0] v;
    int          k;
    x    = (PI_Q30 * 64'(idx)) >> (bits + 1);
    x2   = (x * x) >> 30;
    term = x;
    sum  = x;
    for (k = 1; k <= 8; k++) begin
      prod = (term * x2) >> 30;
      case (k)
        1:       term = prod / 64'd6;
        2:       term = prod / 64'd20;
        3:       term = prod / 64'd42;
        4:       term = prod / 64'd72;
        5:       term = prod / 64'd110;
        6:       term = prod / 64'd156;
        7:       term = prod / 64'd210;
        8:       term = prod / 64'd272;
        default: term = 64'd0;
      endcase
      if (k[0]) begin
        sum = sum - term;
      end else begin
        sum = sum + term;
      end
    end
    v = (sum * 64'd32768 + (64'd1 << 29)) >> 30;
    if (v > 64'd32767) begin
      v = 64'd32767;
    end
    return v[MAG_W-1:0];
  endfunction

endpackage

// ===== hdl/qstg_note_conv.sv =====
// Four-stage converter from frequency/duration to phase step and sample count.
// Uses qstg_pkg (widths, reciprocal constants, note_t).
module qstg_note_conv (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_take,
  input  logic                         in_enq,
  input  logic [qstg_pkg::FREQ_W-1:0]  in_freq,
  input  logic [qstg_pkg::DUR_W-1:0]   in_dur,
  output qstg_pkg::note_t              note
);

  localparam int X_W   = qstg_pkg::X_W;
  localparam int Y_W   = qstg_pkg::Y_W;
  localparam int Q_W   = qstg_pkg::Q_W;
  localparam int CW    = qstg_pkg::CNT_W;
  localparam int PW    = qstg_pkg::PHASE_W;
  localparam int RX_W  = qstg_pkg::RX_W;
  localparam int RY_W  = qstg_pkg::RY_W;
  localparam int PX_W  = X_W + qstg_pkg::MX_W;
  localparam int PY_W  = Y_W + qstg_pkg::MY_W;

  // stage A: products of the inputs
  logic          a_vld_r, a_enq_r;
  logic [X_W-1:0] a_x_r, a_x_nxt;
  logic [PW-1:0]  a_fq_r, a_fq_nxt;
  logic [Y_W-1:0] a_y_r, a_y_nxt;
  // stage B: reciprocal estimates
  logic          b_vld_r, b_enq_r;
  logic [X_W-1:0] b_x_r;
  logic [PW-1:0]  b_fq_r;
  logic [Y_W-1:0] b_y_r;
  logic [Q_W-1:0] b_qe_r, b_qe_nxt;
  logic [CW-1:0]  b_ce_r, b_ce_nxt;
  logic [PX_W-1:0] prod_x;
  logic [PY_W-1:0] prod_y;
  // stage C: remainders
  logic           c_vld_r, c_enq_r;
  logic [PW-1:0]  c_fq_r;
  logic [Q_W-1:0] c_qe_r;
  logic [CW-1:0]  c_ce_r;
  logic [RX_W-1:0] c_rx_r, c_rx_nxt;
  logic [RY_W-1:0] c_ry_r, c_ry_nxt;
  // stage D: corrected results
  logic           d_vld_r, d_enq_r;
  logic [PW-1:0]  d_step_r, d_step_nxt;
  logic [CW-1:0]  d_cnt_r, d_cnt_nxt;
  logic [Q_W-1:0] d_q;

  always_comb begin
    a_x_nxt  = X_W'(in_freq) * X_W'(qstg_pkg::STEP_R0) + X_W'(qstg_pkg::STEP_HALF);
    a_fq_nxt = PW'(in_freq) * PW'(qstg_pkg::STEP_Q0);
    a_y_nxt  = Y_W'(in_dur) * Y_W'(qstg_pkg::SAMPLE_RATE);

    prod_x   = PX_W'(a_x_r) * PX_W'(qstg_pkg::STEP_MX);
    prod_y   = PY_W'(a_y_r) * PY_W'(qstg_pkg::CNT_MY);
    b_qe_nxt = prod_x[X_W +: Q_W];
    b_ce_nxt = prod_y[Y_W +: CW];

    c_rx_nxt = RX_W'(b_x_r - X_W'(b_qe_r) * X_W'(qstg_pkg::SAMPLE_RATE));
    c_ry_nxt = RY_W'(b_y_r - Y_W'(b_ce_r) * Y_W'(qstg_pkg::MS_PER_SEC));

    // estimate is at most one short
    d_q        = c_qe_r + Q_W'(c_rx_r >= RX_W'(qstg_pkg::SAMPLE_RATE));
    d_step_nxt = c_fq_r + PW'(d_q);
    d_cnt_nxt  = c_ce_r + CW'(c_ry_r >= RY_W'(qstg_pkg::MS_PER_SEC));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
      b_vld_r <= 1'b0;
      c_vld_r <= 1'b0;
      d_vld_r <= 1'b0;
    end else begin
      a_vld_r <= in_take;
      b_vld_r <= a_vld_r;
      c_vld_r <= b_vld_r;
      d_vld_r <= c_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    a_enq_r  <= in_enq;
    a_x_r    <= a_x_nxt;
    a_fq_r   <= a_fq_nxt;
    a_y_r    <= a_y_nxt;
    b_enq_r  <= a_enq_r;
    b_x_r    <= a_x_r;
    b_fq_r   <= a_fq_r;
    b_y_r    <= a_y_r;
    b_qe_r   <= b_qe_nxt;
    b_ce_r   <= b_ce_nxt;
    c_enq_r  <= b_enq_r;
    c_fq_r   <= b_fq_r;
    c_qe_r   <= b_qe_r;
    c_ce_r   <= b_ce_r;
    c_rx_r   <= c_rx_nxt;
    c_ry_r   <= c_ry_nxt;
    d_enq_r  <= c_enq_r;
    d_step_r <= d_step_nxt;
    d_cnt_r  <= d_cnt_nxt;
  end

  assign note.valid = d_vld_r;
  assign note.enq   = d_enq_r;
  assign note.step  = d_step_r;
  assign note.count = d_cnt_r;

endmodule

// ===== hdl/qstg_tone_queue.sv =====
// Tone FIFO, phase accumulator and per-word queue bookkeeping.
// Uses qstg_pkg (note_t, status_t, queue constants).
module qstg_tone_queue #(
  parameter int TABLE_BITS = 10
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  qstg_pkg::note_t              note,
  output qstg_pkg::status_t            stat_r,
  output logic [1:0]                   quad_r,
  output logic [TABLE_BITS-1:0]        k_r
);

  localparam int PW = qstg_pkg::PHASE_W;
  localparam int CW = qstg_pkg::CNT_W;
  localparam int AW = qstg_pkg::QPTR_W;
  localparam int FW = qstg_pkg::FILL_W;

  logic [PW-1:0] step_mem [qstg_pkg::QUEUE_DEPTH];
  logic [CW-1:0] cnt_mem  [qstg_pkg::QUEUE_DEPTH];

  logic [PW-1:0] phase_r, phase_nxt;
  logic [AW-1:0] head_r, head_nxt;
  logic [AW-1:0] tail_r, tail_nxt;
  logic [FW-1:0] fill_r, fill_nxt;

  logic [PW-1:0] head_step;
  logic [CW-1:0] cnt_dec;
  logic          enq_live, full, push, rej, tick, retire;
  qstg_pkg::status_t stat_nxt;

  always_comb begin
    head_step = step_mem[head_r];
    cnt_dec   = cnt_mem[head_r] - CW'(1);
    full      = (fill_r == FW'(qstg_pkg::QUEUE_DEPTH));
    // zero-length tones are dropped without a flag
    enq_live  = note.valid && note.enq && (note.count != '0);
    push      = enq_live && !full;
    rej       = enq_live && full;
    tick      = note.valid && !note.enq && (fill_r != '0);
    retire    = tick && (cnt_dec == '0);

    phase_nxt = tick ? phase_r + head_step : phase_r;
    head_nxt  = retire ? head_r + AW'(1) : head_r;
    tail_nxt  = push ? tail_r + AW'(1) : tail_r;
    if (push) begin
      fill_nxt = fill_r + FW'(1);
    end else if (retire) begin
      fill_nxt = fill_r - FW'(1);
    end else begin
      fill_nxt = fill_r;
    end

    stat_nxt.valid    = note.valid;
    stat_nxt.playing  = tick;
    stat_nxt.rejected = rej;
    stat_nxt.fill     = fill_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= '0;
      head_r  <= '0;
      tail_r  <= '0;
      fill_r  <= '0;
      stat_r  <= '0;
    end else begin
      phase_r <= phase_nxt;
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      fill_r  <= fill_nxt;
      stat_r  <= stat_nxt;
    end
  end

  // lookup uses the phase before this word's advance
  always_ff @(posedge clk) begin
    quad_r <= phase_r[PW-1 -: 2];
    k_r    <= phase_r[PW-3 -: TABLE_BITS];
  end

  always_ff @(posedge clk) begin
    if (push) begin
      step_mem[tail_r] <= note.step;
      cnt_mem[tail_r]  <= note.count;
    end else if (tick && !retire) begin
      cnt_mem[head_r] <= cnt_dec;
    end
  end

endmodule

// ===== hdl/qstg_sine_rom.sv =====
// Quarter-wave sine ROM with quadrant folding and registered read.
// Contents built at elaboration from qstg_pkg::sine_mag.
module qstg_sine_rom #(
  parameter int TABLE_BITS = 10
) (
  input  logic                         clk,
  input  logic                         quad_odd,
  input  logic [TABLE_BITS-1:0]        k,
  output logic [qstg_pkg::MAG_W-1:0]   mag_r
);

  localparam int QUARTER = 1 << TABLE_BITS;
  localparam int ADDR_W  = TABLE_BITS + 1;

  typedef logic [qstg_pkg::MAG_W-1:0] rom_t [QUARTER + 1];

  function automatic rom_t build_rom();
    rom_t r;
    int   i;
    for (i = 0; i <= QUARTER; i++) begin
      r[i] = qstg_pkg::sine_mag(i, TABLE_BITS);
    end
    return r;
  endfunction

  localparam rom_t SINE_ROM = build_rom();

  logic [ADDR_W-1:0] addr;

  // odd quadrants run the table backwards
  assign addr = quad_odd ? ADDR_W'(QUARTER) - {1'b0, k} : {1'b0, k};

  always_ff @(posedge clk) begin
    mag_r <= SINE_ROM[addr];
  end

endmodule

// ===== hdl/qstg_res_fifo.sv =====
// Result buffer between the pipeline and the output channel.
// Uses qstg_pkg (res_t, RES_DEPTH).
module qstg_res_fifo (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  qstg_pkg::res_t push_data,
  input  logic           pop,
  output logic           out_valid,
  output qstg_pkg::res_t out_data
);

  localparam int AW = qstg_pkg::RES_PTR_W;
  localparam int CW = qstg_pkg::RES_CNT_W;

  qstg_pkg::res_t mem [qstg_pkg::RES_DEPTH];

  logic [AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] count_r, count_nxt;

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + CW'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + AW'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + AW'(1);
      end
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_data;
    end
  end

  assign out_valid = (count_r != '0);
  assign out_data  = mem[rd_ptr_r];

endmodule

// ===== hdl/queued_sine_tone_generator.sv =====
// Queued sine tone generator: tone queue plus DDS sample path.
// Result path: converter stages A-D, queue status, ROM and scale stages, result buffer.
// Throughput: one word per cycle; in_stall rises only when 16 words are outstanding
// (the size of the result buffer), so the input keeps flowing while a result waits.
// Reset (synchronous, active low): queue empty, phase 0, amplitude 28000, buffer empty.
module queued_sine_tone_generator #(
  parameter int SINE_TABLE_BITS = 10
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic                                 in_cmd,
  input  logic [qstg_pkg::FREQ_W-1:0]          in_freq_sixteenths,
  input  logic [qstg_pkg::DUR_W-1:0]           in_duration_ms,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [qstg_pkg::SAMPLE_W-1:0] out_sample,
  output logic [qstg_pkg::FILL_W-1:0]          out_queue_fill,
  output logic                                 out_rejected,
  output logic                                 out_playing,
  input  logic                                 cfg_wr_en,
  input  logic [qstg_pkg::AMP_W-1:0]           cfg_wr_data
);

  localparam int AMP_W  = qstg_pkg::AMP_W;
  localparam int MAG_W  = qstg_pkg::MAG_W;
  localparam int PROD_W = AMP_W + MAG_W;
  localparam int SW     = qstg_pkg::SAMPLE_W;
  localparam int OCW    = qstg_pkg::RES_CNT_W;

  logic [AMP_W-1:0] amp_r;
  logic [OCW-1:0]   outstanding_r, outstanding_nxt;
  logic             in_take, out_take;

  qstg_pkg::note_t   note;
  qstg_pkg::status_t e_stat_r;
  logic [1:0]                   e_quad_r;
  logic [SINE_TABLE_BITS-1:0]   e_k_r;

  // ROM stage
  qstg_pkg::status_t f_stat_r;
  logic              f_neg_r;
  logic [MAG_W-1:0]  f_mag_r;
  // scale stage
  qstg_pkg::status_t g_stat_r;
  logic              g_neg_r;
  logic [PROD_W-1:0] g_prod_r;

  logic [PROD_W:0]   rnd;
  logic [SW-1:0]     mag_val;
  qstg_pkg::res_t    res;
  qstg_pkg::res_t    head;

  assign in_take  = in_valid && !in_stall;
  assign out_take = out_valid && !out_stall;
  assign in_stall = (outstanding_r == OCW'(qstg_pkg::RES_DEPTH));

  always_comb begin
    outstanding_nxt = outstanding_r;
    if (in_take && !out_take) begin
      outstanding_nxt = outstanding_r + OCW'(1);
    end else if (out_take && !in_take) begin
      outstanding_nxt = outstanding_r - OCW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      amp_r         <= qstg_pkg::AMP_RESET;
      outstanding_r <= '0;
      f_stat_r      <= '0;
      g_stat_r      <= '0;
    end else begin
      if (cfg_wr_en) begin
        amp_r <= cfg_wr_data;
      end
      outstanding_r <= outstanding_nxt;
      f_stat_r      <= e_stat_r;
      g_stat_r      <= f_stat_r;
    end
  end

  always_ff @(posedge clk) begin
    f_neg_r  <= e_quad_r[1];
    g_neg_r  <= f_neg_r;
    g_prod_r <= PROD_W'(amp_r) * PROD_W'(f_mag_r);
  end

  qstg_note_conv u_conv (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_take (in_take),
    .in_enq  (in_cmd),
    .in_freq (in_freq_sixteenths),
    .in_dur  (in_duration_ms),
    .note    (note)
  );

  qstg_tone_queue #(
    .TABLE_BITS (SINE_TABLE_BITS)
  ) u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .note   (note),
    .stat_r (e_stat_r),
    .quad_r (e_quad_r),
    .k_r    (e_k_r)
  );

  qstg_sine_rom #(
    .TABLE_BITS (SINE_TABLE_BITS)
  ) u_rom (
    .clk      (clk),
    .quad_odd (e_quad_r[0]),
    .k        (e_k_r),
    .mag_r    (f_mag_r)
  );

  // round to nearest, then sign by quadrant
  always_comb begin
    rnd     = {1'b0, g_prod_r} + (PROD_W + 1)'(1 << (MAG_W - 1));
    mag_val = rnd[MAG_W +: SW];
    if (!g_stat_r.playing) begin
      res.sample = '0;
    end else if (g_neg_r) begin
      res.sample = -$signed(mag_val);
    end else begin
      res.sample = $signed(mag_val);
    end
    res.fill     = g_stat_r.fill;
    res.rejected = g_stat_r.rejected;
    res.playing  = g_stat_r.playing;
  end

  qstg_res_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (g_stat_r.valid),
    .push_data (res),
    .pop       (out_take),
    .out_valid (out_valid),
    .out_data  (head)
  );

  assign out_sample     = head.sample;
  assign out_queue_fill = head.fill;
  assign out_rejected   = head.rejected;
  assign out_playing    = head.playing;

endmodule

// ===== bench/qstg_tb_pkg.sv =====
// Command codes and field limits shared by the tone generator bench files.
// Used by bench/qstg_checker.sv and bench/tb.sv; depends on nothing else.
package qstg_tb_pkg;

  typedef enum logic {
    CMD_TICK    = 1'b0,
    CMD_ENQUEUE = 1'b1
  } tone_cmd_e;

  localparam int FREQ_TOP = 352800;
  localparam int DUR_TOP  = 65535;
  localparam int AMP_TOP  = 32767;

endpackage

// ===== bench/qstg_checker.sv =====
// Watches the word channels of the queued tone generator, models the tone queue
// and DDS sample path, and compares every result word. Depends on qstg_pkg, qstg_tb_pkg.
module qstg_checker (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  input  logic                                 in_stall,
  input  logic                                 in_cmd,
  input  logic [qstg_pkg::FREQ_W-1:0]          in_freq_sixteenths,
  input  logic [qstg_pkg::DUR_W-1:0]           in_duration_ms,
  input  logic                                 out_valid,
  input  logic                                 out_stall,
  input  logic signed [qstg_pkg::SAMPLE_W-1:0] out_sample,
  input  logic [qstg_pkg::FILL_W-1:0]          out_queue_fill,
  input  logic                                 out_rejected,
  input  logic                                 out_playing,
  input  logic                                 cfg_wr_en,
  input  logic [qstg_pkg::AMP_W-1:0]           cfg_wr_data,
  output int                                   fail_count,
  output int                                   pending_words
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int              TAB_BITS   = 10;
  localparam int              TAB_N      = 1 << TAB_BITS;
  localparam int              TONE_SLOTS = 16;
  localparam longint unsigned SAMPLE_HZ  = 64'd44100;
  localparam longint unsigned PI_Q30     = 64'd3373259426;

  logic [14:0]     sine_rom [0:TAB_N];
  logic [31:0]     acc_phase;
  logic [31:0]     slot_step [TONE_SLOTS];
  longint unsigned slot_left [TONE_SLOTS];
  int              q_head;
  int              q_tail;
  int              q_fill;
  logic [14:0]     amp;
  qstg_pkg::res_t  expected_words [$];
  int              errors;

  assign fail_count = errors;

  // sin(pi/2 * i / TAB_N) as a truncating Q30 Taylor series, rounded to Q15
  function automatic logic [14:0] quarter_sine(input int i);
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint unsigned acc;
    longint unsigned v;
    int              k;
    x    = (PI_Q30 * 64'(i)) / 64'(2 * TAB_N);
    x2   = (x * x) >> 30;
    term = x;
    acc  = x;
    for (k = 1; k <= 8; k++) begin
      term = ((term * x2) >> 30) / 64'((2 * k) * (2 * k + 1));
      if (k % 2 == 1) begin
        acc = acc - term;
      end else begin
        acc = acc + term;
      end
    end
    v = (acc * 64'd32768 + 64'd536870912) >> 30;
    if (v > 64'd32767) begin
      v = 64'd32767;
    end
    return v[14:0];
  endfunction

  initial begin
    for (int i = 0; i <= TAB_N; i++) begin
      sine_rom[i] = quarter_sine(i);
    end
  end

  task automatic play_or_queue(input logic cmd, input logic [qstg_pkg::FREQ_W-1:0] f,
                               input logic [qstg_pkg::DUR_W-1:0] ms,
                               output qstg_pkg::res_t r);
    longint unsigned len;
    longint unsigned stp;
    logic [1:0]      quad;
    int              k_idx;
    logic [14:0]     mag;
    logic [31:0]     val;
    r = '0;
    if (cmd == qstg_tb_pkg::CMD_ENQUEUE) begin
      len = (64'(ms) * SAMPLE_HZ) / 64'd1000;
      stp = ((64'(f) << 28) + SAMPLE_HZ / 2) / SAMPLE_HZ;
      if (len != 0) begin
        if (q_fill >= TONE_SLOTS) begin
          r.rejected = 1'b1;
        end else begin
          slot_step[q_tail] = stp[31:0];
          slot_left[q_tail] = len;
          q_tail = (q_tail == TONE_SLOTS - 1) ? 0 : q_tail + 1;
          q_fill++;
        end
      end
    end else if (q_fill != 0) begin
      quad  = acc_phase[31:30];
      k_idx = int'(acc_phase[29 -: TAB_BITS]);
      mag   = quad[0] ? sine_rom[TAB_N - k_idx] : sine_rom[k_idx];
      val   = (32'(amp) * 32'(mag) + 32'd16384) >> 15;
      r.sample  = quad[1] ? 16'(32'd0 - val) : 16'(val);
      r.playing = 1'b1;
      // phase carries over from one tone to the next
      acc_phase = acc_phase + slot_step[q_head];
      slot_left[q_head]--;
      if (slot_left[q_head] == 0) begin
        q_head = (q_head == TONE_SLOTS - 1) ? 0 : q_head + 1;
        q_fill--;
      end
    end
    r.fill = 5'(q_fill);
  endtask

  task automatic log_mismatch(input string what, input qstg_pkg::res_t exp_w);
    errors++;
    if (errors <= 10) begin
      $display("qstg_checker: %0t ns: %s: expected sample %0d fill %0d rej %0b play %0b",
               $time, what, exp_w.sample, exp_w.fill, exp_w.rejected, exp_w.playing);
      $display("qstg_checker:   got sample %0d fill %0d rej %0b play %0b",
               out_sample, out_queue_fill, out_rejected, out_playing);
    end
  endtask

  always @(posedge clk) begin
    qstg_pkg::res_t exp_w;
    if (!rst_n) begin
      acc_phase = '0;
      q_head    = 0;
      q_tail    = 0;
      q_fill    = 0;
      amp       = qstg_pkg::AMP_RESET;
      errors    = 0;
      expected_words.delete();
      pending_words <= 0;
    end else begin
      if (cfg_wr_en) begin
        amp = cfg_wr_data;
      end
      if (out_valid && !out_stall) begin
        if (expected_words.size() == 0) begin
          log_mismatch("result word with nothing expected", '0);
        end else begin
          exp_w = expected_words.pop_front();
          if (out_sample !== exp_w.sample || out_queue_fill !== exp_w.fill ||
              out_rejected !== exp_w.rejected || out_playing !== exp_w.playing) begin
            log_mismatch("result word mismatch", exp_w);
          end
        end
      end
      if (in_valid && !in_stall) begin
        play_or_queue(in_cmd, in_freq_sixteenths, in_duration_ms, exp_w);
        expected_words.push_back(exp_w);
      end
      pending_words <= expected_words.size();
    end
  end

endmodule

// ===== bench/tb.sv =====
// Stimulus and verdict for the queued sine tone generator: directed words, three random
// phases with different idling and amplitude, and a long output hold-off.
// Depends on qstg_pkg, qstg_tb_pkg, qstg_checker and the RTL top.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LIMIT_CYCLES = 100000;
  localparam int HOLD_LEN     = 200;
  localparam int PHASE_WORDS  = 125;

  logic                                 clk = 1'b0;
  logic                                 rst_n = 1'b0;
  logic                                 in_valid = 1'b0;
  logic                                 in_stall;
  logic                                 in_cmd = 1'b0;
  logic [qstg_pkg::FREQ_W-1:0]          in_freq_sixteenths = '0;
  logic [qstg_pkg::DUR_W-1:0]           in_duration_ms = '0;
  logic                                 out_valid;
  logic                                 out_stall = 1'b0;
  logic signed [qstg_pkg::SAMPLE_W-1:0] out_sample;
  logic [qstg_pkg::FILL_W-1:0]          out_queue_fill;
  logic                                 out_rejected;
  logic                                 out_playing;
  logic                                 cfg_wr_en = 1'b0;
  logic [qstg_pkg::AMP_W-1:0]           cfg_wr_data = '0;
  int                                   fail_count;
  int                                   pending_words;
  int                                   send_idle_pct = 13;
  int                                   recv_idle_pct = 63;
  logic                                 pressure_req = 1'b0;
  int                                   hold_cycles = 0;
  int                                   cycle_cnt = 0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  queued_sine_tone_generator dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_cmd             (in_cmd),
    .in_freq_sixteenths (in_freq_sixteenths),
    .in_duration_ms     (in_duration_ms),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_sample         (out_sample),
    .out_queue_fill     (out_queue_fill),
    .out_rejected       (out_rejected),
    .out_playing        (out_playing),
    .cfg_wr_en          (cfg_wr_en),
    .cfg_wr_data        (cfg_wr_data)
  );

  qstg_checker chk (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_cmd             (in_cmd),
    .in_freq_sixteenths (in_freq_sixteenths),
    .in_duration_ms     (in_duration_ms),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_sample         (out_sample),
    .out_queue_fill     (out_queue_fill),
    .out_rejected       (out_rejected),
    .out_playing        (out_playing),
    .cfg_wr_en          (cfg_wr_en),
    .cfg_wr_data        (cfg_wr_data),
    .fail_count         (fail_count),
    .pending_words      (pending_words)
  );

  // result side: random stall, plus one long hold-off once requested
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall   <= 1'b0;
      hold_cycles <= 0;
    end else if (pressure_req && hold_cycles < HOLD_LEN) begin
      out_stall   <= 1'b1;
      hold_cycles <= hold_cycles + 1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    end
  end

  task automatic send_word(input qstg_tb_pkg::tone_cmd_e cmd, input int f, input int ms);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid           <= 1'b1;
    in_cmd             <= cmd;
    in_freq_sixteenths <= f[qstg_pkg::FREQ_W-1:0];
    in_duration_ms     <= ms[qstg_pkg::DUR_W-1:0];
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_words != 0) @(posedge clk);
  endtask

  task automatic write_amplitude(input int value);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value[qstg_pkg::AMP_W-1:0];
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  // mostly ticks so tones play out; short tones keep the queue turning over
  task automatic run_random(input int n);
    int pick;
    int ms;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 24) == 0) begin
        pick = $urandom_range(0, 9);
        ms   = (pick == 0) ? 0 : (pick <= 7) ? 1 : pick - 6;
        send_word(qstg_tb_pkg::CMD_ENQUEUE, $urandom_range(0, qstg_tb_pkg::FREQ_TOP), ms);
      end else begin
        send_word(qstg_tb_pkg::CMD_TICK, $urandom_range(0, qstg_tb_pkg::FREQ_TOP),
                  $urandom_range(0, qstg_tb_pkg::DUR_TOP));
      end
    end
  endtask

  initial begin
    while (cycle_cnt < LIMIT_CYCLES) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("tb: done, errors");
    $finish;
  end

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: idle tick, zero-length drop, at-Nyquist, zero frequency, fill to full
    send_word(qstg_tb_pkg::CMD_TICK, qstg_tb_pkg::FREQ_TOP, qstg_tb_pkg::DUR_TOP);
    send_word(qstg_tb_pkg::CMD_ENQUEUE, 0, 0);
    send_word(qstg_tb_pkg::CMD_ENQUEUE, qstg_tb_pkg::FREQ_TOP, 1);
    send_word(qstg_tb_pkg::CMD_ENQUEUE, 0, 1);
    send_word(qstg_tb_pkg::CMD_ENQUEUE, 1, 2);
    repeat (13) send_word(qstg_tb_pkg::CMD_ENQUEUE,
                          $urandom_range(0, qstg_tb_pkg::FREQ_TOP), 1);
    send_word(qstg_tb_pkg::CMD_ENQUEUE, 8000, 1);
    send_word(qstg_tb_pkg::CMD_ENQUEUE, 8000, 0);
    repeat (3) send_word(qstg_tb_pkg::CMD_TICK, 0, 0);
    wait_drained();

    write_amplitude(qstg_tb_pkg::AMP_TOP);
    run_random(PHASE_WORDS);
    wait_drained();

    send_idle_pct = 63;
    recv_idle_pct <= 13;
    write_amplitude(0);
    run_random(PHASE_WORDS);
    wait_drained();

    send_idle_pct = 0;
    recv_idle_pct <= 0;
    write_amplitude($urandom_range(1, qstg_tb_pkg::AMP_TOP - 1));
    pressure_req <= 1'b1;
    run_random(PHASE_WORDS);
    wait_drained();

    // longest tone; it never drains in this run
    send_word(qstg_tb_pkg::CMD_ENQUEUE, qstg_tb_pkg::FREQ_TOP, qstg_tb_pkg::DUR_TOP);
    repeat (4) send_word(qstg_tb_pkg::CMD_TICK, 0, 0);
    wait_drained();
    repeat (20) @(posedge clk);

    if (fail_count == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule
